/* rtl/assert_macros.svh */
// assertion macros used by the cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication checked at every clock edge outside reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/lkv_pkg.sv */
// shared constants, codes and types of the lru key/value cache
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int HELD_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// register indexes
	localparam logic REG_CAPACITY = 1'b0;

	// per-cell update controls
	typedef struct packed {
		logic load_prev;
		logic load_next;
		logic upd_valid;
		logic valid_d;
	} cell_ctrl_t;

endpackage

/* rtl/lkv_cell.sv */
// one cell of the recency chain: key, data, valid mark and match flag
module lkv_cell import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmp_en,
	input  logic [KEY_W-1:0]  cmp_key,
	input  cell_ctrl_t        ctrl,
	input  logic [KEY_W-1:0]  prev_key,
	input  logic [DATA_W-1:0] prev_data,
	input  logic [KEY_W-1:0]  next_key,
	input  logic [DATA_W-1:0] next_data,
	output logic [KEY_W-1:0]  key,
	output logic [DATA_W-1:0] data,
	output logic              valid,
	output logic              match
);

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              valid_q;
	logic              match_q;

	// payload moves toward the lru end or back toward the front
	always_ff @(posedge clk) begin
		if (ctrl.load_prev) begin
			key_q  <= prev_key;
			data_q <= prev_data;
		end else if (ctrl.load_next) begin
			key_q  <= next_key;
			data_q <= next_data;
		end
	end

	// valid mark and registered key compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.upd_valid) begin
				valid_q <= ctrl.valid_d;
			end
			if (cmp_en) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	assign key   = key_q;
	assign data  = data_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

/* rtl/lru_key_value_cache.sv */
// lru key/value cache: chain of cells ordered from most to least recently used
// each item passes a compare state, then a shift state that waits for the output register to free
// and registers the result
// a new item is taken in the shift cycle of the previous one if the output register frees
// reset clears valid marks, occupancy and output valid; capacity resets to 16
// no clearing pass: the cache accepts items right after reset
module lru_key_value_cache import lkv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// operation [1:0], key [33:2], value [65:34], zero pad [71:66]
	input  logic [71:0]       s_tdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	// found [0], result_value [32:1], evicted [33], entries_held [38:34], zero pad [39]
	output logic [39:0]       m_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    occ_q;
	logic [OP_W-1:0]     op_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [DATA_W-1:0]   value_s1;

	logic                found_q;
	logic [DATA_W-1:0]   result_q;
	logic                evicted_q;
	logic [HELD_W-1:0]   held_q;
	logic                m_tvalid_q;

	logic [KEY_W-1:0]    key_arr   [ENTRIES];
	logic [DATA_W-1:0]   data_arr  [ENTRIES];
	logic [ENTRIES-1:0]  valid_vec;
	logic [ENTRIES-1:0]  match_vec;
	cell_ctrl_t          ctrl_arr  [ENTRIES];

	logic                s_fire;
	logic                update_go;
	logic                cfg_wr;

	logic [ENTRIES-1:0]  first_hit;
	logic [ENTRIES-1:0]  before_hit;
	logic                hit;
	logic [DATA_W-1:0]   hit_data;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    eff_cap;
	logic [CMP_W-1:0]    occ_ext;
	logic                evict;
	logic [CMP_W-1:0]    put_last;
	logic [CMP_W-1:0]    occ_new;
	logic                do_get;
	logic                do_put;
	logic                do_del;
	logic                op_known;
	logic [DATA_W-1:0]   front_data;
	logic [ENTRIES-1:0]  occ_therm;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = 32'(cap_q);
		end
	end

	// handshakes
	assign update_go = (state_q == ST_UPDATE) && (!m_tvalid_q || m_tready);
	assign s_tready  = (state_q == ST_IDLE) || update_go;
	assign s_fire    = s_tvalid && s_tready;

	// first matching position and the cells in front of it
	assign first_hit  = match_vec & (~match_vec + ENTRIES'(1));
	assign before_hit = first_hit - ENTRIES'(1);
	assign hit        = |match_vec;

	always_comb begin
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_data = hit_data | (data_arr[i] & {DATA_W{first_hit[i]}});
		end
	end

	// capacity clamp and new occupancy
	assign cap_ext = CMP_W'(cap_q);
	assign occ_ext = CMP_W'(occ_q);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign evict    = occ_ext >= eff_cap;
	assign put_last = evict ? (eff_cap - CMP_W'(1)) : occ_ext;

	assign do_get = (op_s1 == OP_GET) && hit;
	assign do_put = (op_s1 == OP_PUT) && !hit;
	assign do_del = (op_s1 == OP_DELETE) && hit;

	// the unused code reports no hit
	assign op_known = (op_s1 == OP_GET) || (op_s1 == OP_PUT) || (op_s1 == OP_DELETE);

	always_comb begin
		if (do_put) begin
			occ_new = put_last + CMP_W'(1);
		end else if (do_del) begin
			occ_new = occ_ext - CMP_W'(1);
		end else begin
			occ_new = occ_ext;
		end
	end

	assign front_data = do_get ? hit_data : value_s1;

	// per-cell controls for the shift cycle
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ctrl_arr[i].load_prev = update_go && (
				(do_get && (before_hit[i] || first_hit[i])) ||
				(do_put && (CMP_W'(i) <= put_last)));
			ctrl_arr[i].load_next = update_go && do_del && !before_hit[i] &&
				(CMP_W'(i + 1) < occ_ext);
			ctrl_arr[i].upd_valid = update_go;
			ctrl_arr[i].valid_d   = CMP_W'(i) < occ_new;
		end
	end

	// the cell chain
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic [KEY_W-1:0]  prev_key;
		logic [DATA_W-1:0] prev_data;
		logic [KEY_W-1:0]  next_key;
		logic [DATA_W-1:0] next_data;

		if (g == 0) begin : g_front
			assign prev_key  = key_s1;
			assign prev_data = front_data;
		end else begin : g_mid
			assign prev_key  = key_arr[g-1];
			assign prev_data = data_arr[g-1];
		end

		if (g == ENTRIES - 1) begin : g_back
			assign next_key  = '0;
			assign next_data = '0;
		end else begin : g_inner
			assign next_key  = key_arr[g+1];
			assign next_data = data_arr[g+1];
		end

		lkv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_en    (state_q == ST_COMPARE),
			.cmp_key   (key_s1),
			.ctrl      (ctrl_arr[g]),
			.prev_key  (prev_key),
			.prev_data (prev_data),
			.next_key  (next_key),
			.next_data (next_data),
			.key       (key_arr[g]),
			.data      (data_arr[g]),
			.valid     (valid_vec[g]),
			.match     (match_vec[g])
		);
	end

	// command register
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1    <= s_tdata[1:0];
			key_s1   <= s_tdata[33:2];
			value_s1 <= s_tdata[65:34];
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (update_go) begin
			found_q   <= hit && op_known;
			result_q  <= (do_get || do_del) ? hit_data : '0;
			evicted_q <= do_put && evict;
			held_q    <= HELD_W'(occ_new);
		end
	end

	// sequencer, occupancy, capacity and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			occ_q      <= '0;
			cap_q      <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q <= pwdata[CAP_W-1:0];
			end
			if (update_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_COMPARE;
					end
				end
				ST_COMPARE: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (update_go) begin
						occ_q   <= CNT_W'(occ_new);
						state_q <= s_fire ? ST_COMPARE : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, held_q, evicted_q, result_q, found_q};

	// valid marks always form a prefix of length occupancy
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			occ_therm[i] = CNT_W'(i) < occ_q;
		end
	end

	`ASSERT_ALWAYS(a_occ_bound, occ_ext <= CMP_W'(ENTRIES), "occupancy above entry count")
	`ASSERT_ALWAYS(a_valid_prefix, valid_vec == occ_therm, "valid marks not packed at front")
	`ASSERT_IMPLY(a_single_match, state_q == ST_UPDATE, $onehot0(match_vec), "duplicate key held")

endmodule
